### hdl/mmac_pkg.sv
// Shared types and constants for the min/max axis calibrator.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package mmac_pkg;

   localparam int SAMPLE_W = 16;                // raw reading and normalized result
   localparam int CENTRE_W = 17;                // max + min
   localparam int SPAN_W   = 18;                // max - min, signed
   localparam int DIFF_W   = 19;                // 2*raw - centre, signed
   localparam int MAG_W    = 17;                // magnitude of 2*raw - centre
   localparam int QUO_W    = 17;                // quotient bits before rounding
   localparam int REM_W    = 18;                // partial remainder
   localparam int CNT_W    = $clog2(QUO_W);
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;
   localparam int LANES    = 3;

   localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_OBSERVE   = 2'd0,
      CMD_CLEAR     = 2'd1,
      CMD_CALIBRATE = 2'd2,
      CMD_TRANSFORM = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_SPAN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   // control from the sequencer to each divider lane
   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

### hdl/mmac_req_if.sv
// Request channel: command and one raw three-axis sample per word.
// Depends on mmac_pkg for field widths.
`timescale 1ns / 1ps

interface mmac_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [mmac_pkg::CMD_W-1:0]           command;
   logic signed [mmac_pkg::SAMPLE_W-1:0] sample_x;
   logic signed [mmac_pkg::SAMPLE_W-1:0] sample_y;
   logic signed [mmac_pkg::SAMPLE_W-1:0] sample_z;

   modport source (output valid, command, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, command, sample_x, sample_y, sample_z, output ready);
endinterface

### hdl/mmac_rsp_if.sv
// Response channel: normalized three-axis result and status per word.
// Depends on mmac_pkg for field widths.
`timescale 1ns / 1ps

interface mmac_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mmac_pkg::SAMPLE_W-1:0] norm_x;
   logic signed [mmac_pkg::SAMPLE_W-1:0] norm_y;
   logic signed [mmac_pkg::SAMPLE_W-1:0] norm_z;
   logic [mmac_pkg::STAT_W-1:0]          status;

   modport source (output valid, norm_x, norm_y, norm_z, status, input ready);
   modport sink   (input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

### hdl/mmac_div_lane.sv
// One bit-serial restoring divider lane: (mag << (FRAC_BITS+1)) / dvs.
// Depends on mmac_pkg; instantiated once per axis by the top level.
`timescale 1ns / 1ps

module mmac_div_lane #(
   parameter int FRAC_BITS = 12
) (
   input  logic                          clock,
   input  mmac_pkg::div_ctl_type         ctl,
   input  logic [mmac_pkg::MAG_W-1:0]    mag,
   input  logic [mmac_pkg::QUO_W-1:0]    dvs,
   output logic [mmac_pkg::QUO_W-1:0]    quo,
   output logic                          ovf
);

   localparam int NUM_W = mmac_pkg::MAG_W + FRAC_BITS + 1;

   logic [NUM_W-1:0]              num;
   logic [mmac_pkg::REM_W-1:0]    hi;
   logic [mmac_pkg::REM_W-1:0]    dvs_ext;
   logic [mmac_pkg::REM_W-1:0]    trial;
   logic                          fits;

   logic [mmac_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [mmac_pkg::QUO_W-1:0]    sh_ff, sh_in;
   logic [mmac_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic                          ovf_ff, ovf_in;

   assign num     = {mag, (FRAC_BITS + 1)'(0)};
   assign hi      = mmac_pkg::REM_W'(num[NUM_W-1:mmac_pkg::QUO_W]);
   assign dvs_ext = mmac_pkg::REM_W'(dvs);
   assign trial   = {rem_ff[mmac_pkg::REM_W-2:0], sh_ff[mmac_pkg::QUO_W-1]};
   assign fits    = (trial >= dvs_ext);

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (ctl.load) begin
         // upper part must already be below the divisor, else the quotient overflows
         rem_in = hi;
         sh_in  = num[mmac_pkg::QUO_W-1:0];
         quo_in = '0;
         ovf_in = (hi >= dvs_ext);
      end else if (ctl.step) begin
         rem_in = fits ? (trial - dvs_ext) : trial;
         sh_in  = {sh_ff[mmac_pkg::QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[mmac_pkg::QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quo = quo_ff;
   assign ovf = ovf_ff;

endmodule

### hdl/minmax_axis_calibrator.sv
// Min/max three-axis calibrator with hard-iron offset and scale correction.
// Request word: command plus three signed 16-bit readings; every request
// returns exactly one response word (norm_x/y/z in signed fixed point with
// FRAC_BITS fraction bits, and a status code).
// Observe folds the sample into the per-axis running min and max, clear
// returns them to their extremes, calibrate latches max+min and max-min,
// transform returns (2*raw - sum)/span rounded and saturated.
// Observe, clear, calibrate and a transform with a non-positive span go from
// idle straight to the finish step, which loads the response word. A good
// transform passes a setup step, then the bit-serial dividers (one quotient
// bit per cycle, all axes in parallel lanes), then the finish step, which
// rounds and loads the response.
// One request is in flight at a time; req ready is high only while idle.
// The response sits in an output register, so a new request is taken while
// the last response still waits; a stalled receiver holds the response and
// the next one waits in the finish step.
// Reset (synchronous, active high) sets min to 32767, max to -32768, the
// latched sum and span to zero, and drops any pending response.
`timescale 1ns / 1ps

module minmax_axis_calibrator #(
   parameter int FRAC_BITS = 12,
   parameter int AXES      = 3
) (
   input  logic       clock,
   input  logic       reset,
   mmac_req_if.sink   req_chan,
   mmac_rsp_if.source rsp_chan
);

   localparam int SW = mmac_pkg::SAMPLE_W;

   mmac_pkg::state_type   state_ff, state_in;
   mmac_pkg::div_ctl_type div_ctl;
   mmac_pkg::cmd_type     req_cmd;

   logic                          req_take;
   logic                          out_free;
   logic                          out_load;
   logic                          bad_now;
   logic                          div_done;

   logic signed [SW-1:0]          raw [mmac_pkg::LANES];

   logic signed [SW-1:0]               min_ff    [AXES];
   logic signed [SW-1:0]               max_ff    [AXES];
   logic [mmac_pkg::CENTRE_W-1:0]      centre_ff [AXES];
   logic [mmac_pkg::SPAN_W-1:0]        span_ff   [AXES];
   logic signed [SW-1:0]               samp_ff   [AXES];
   logic                               neg_ff    [AXES];

   logic [mmac_pkg::DIFF_W-1:0]   diff [AXES];
   logic [mmac_pkg::MAG_W-1:0]    mag  [AXES];
   logic [mmac_pkg::QUO_W-1:0]    quo  [AXES];
   logic                          ovf  [AXES];
   logic [mmac_pkg::QUO_W:0]      rnd  [AXES];
   logic [mmac_pkg::QUO_W-1:0]    qr   [AXES];
   logic                          sat  [AXES];
   logic signed [SW-1:0]          res  [mmac_pkg::LANES];
   logic [AXES-1:0]               sat_vec;
   logic [AXES-1:0]               bad_vec;

   mmac_pkg::cmd_type             cmd_ff;
   logic                          bad_ff;
   logic [mmac_pkg::CNT_W-1:0]    cnt_ff;

   logic                          rsp_valid_ff;
   logic signed [SW-1:0]          norm_ff [mmac_pkg::LANES];
   mmac_pkg::status_type          status_ff;

   assign raw[0]   = req_chan.sample_x;
   assign raw[1]   = req_chan.sample_y;
   assign raw[2]   = req_chan.sample_z;
   assign req_cmd  = mmac_pkg::cmd_type'(req_chan.command);
   assign req_take = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign div_done = (cnt_ff == mmac_pkg::CNT_W'(mmac_pkg::QUO_W - 1));
   assign bad_now  = |bad_vec;

   // ---------------- per-axis state and divider lanes ----------------
   for (genvar l = 0; l < AXES; l++) begin : g_axis
      assign bad_vec[l] = span_ff[l][mmac_pkg::SPAN_W-1] || (span_ff[l] == '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            min_ff[l]    <= mmac_pkg::S16_MAX;
            max_ff[l]    <= mmac_pkg::S16_MIN;
            centre_ff[l] <= '0;
            span_ff[l]   <= '0;
         end else if (req_take) begin
            case (req_cmd)
               mmac_pkg::CMD_OBSERVE: begin
                  if (raw[l] < min_ff[l]) min_ff[l] <= raw[l];
                  if (raw[l] > max_ff[l]) max_ff[l] <= raw[l];
               end
               mmac_pkg::CMD_CLEAR: begin
                  min_ff[l] <= mmac_pkg::S16_MAX;
                  max_ff[l] <= mmac_pkg::S16_MIN;
               end
               mmac_pkg::CMD_CALIBRATE: begin
                  centre_ff[l] <= {max_ff[l][SW-1], max_ff[l]} + {min_ff[l][SW-1], min_ff[l]};
                  span_ff[l]   <= {{2{max_ff[l][SW-1]}}, max_ff[l]}
                                - {{2{min_ff[l][SW-1]}}, min_ff[l]};
               end
               default: ;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (req_take) samp_ff[l] <= raw[l];
         if (div_ctl.load) neg_ff[l] <= diff[l][mmac_pkg::DIFF_W-1];
      end

      // 2*raw - sum, then its magnitude
      assign diff[l] = {{2{samp_ff[l][SW-1]}}, samp_ff[l], 1'b0}
                     - {{2{centre_ff[l][mmac_pkg::CENTRE_W-1]}}, centre_ff[l]};
      assign mag[l]  = diff[l][mmac_pkg::DIFF_W-1]
                     ? mmac_pkg::MAG_W'(-diff[l]) : mmac_pkg::MAG_W'(diff[l]);

      mmac_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .ctl   (div_ctl),
         .mag   (mag[l]),
         .dvs   (span_ff[l][mmac_pkg::QUO_W-1:0]),
         .quo   (quo[l]),
         .ovf   (ovf[l])
      );

      // round half away from zero: q = (q2 + 1) / 2, then saturate
      assign rnd[l] = {1'b0, quo[l]} + (mmac_pkg::QUO_W + 1)'(1);
      assign qr[l]  = rnd[l][mmac_pkg::QUO_W:1];
      assign sat[l] = ovf[l] || (neg_ff[l]
                      ? (qr[l] > mmac_pkg::QUO_W'(32768))
                      : (qr[l] > mmac_pkg::QUO_W'(32767)));
      assign sat_vec[l] = sat[l];
      assign res[l] = sat[l]
                    ? (neg_ff[l] ? mmac_pkg::S16_MIN : mmac_pkg::S16_MAX)
                    : (neg_ff[l] ? SW'(-qr[l][SW-1:0]) : qr[l][SW-1:0]);
   end

   for (genvar l = AXES; l < mmac_pkg::LANES; l++) begin : g_unused
      assign res[l] = '0;
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_cmd;
         bad_ff <= bad_now;
      end
      if (div_ctl.load) cnt_ff <= '0;
      else if (div_ctl.step) cnt_ff <= cnt_ff + mmac_pkg::CNT_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmac_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == mmac_pkg::CMD_TRANSFORM && !bad_now) state_in = mmac_pkg::ST_PREP;
               else state_in = mmac_pkg::ST_FINISH;
            end
         end
         mmac_pkg::ST_PREP:   state_in = mmac_pkg::ST_DIV;
         mmac_pkg::ST_DIV:    if (div_done) state_in = mmac_pkg::ST_FINISH;
         mmac_pkg::ST_FINISH: if (out_free) state_in = mmac_pkg::ST_IDLE;
         default:             state_in = mmac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      div_ctl.load   = 1'b0;
      div_ctl.step   = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         mmac_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         mmac_pkg::ST_PREP:   div_ctl.load   = 1'b1;
         mmac_pkg::ST_DIV:    div_ctl.step   = 1'b1;
         mmac_pkg::ST_FINISH: out_load       = out_free;
         default: ;
      endcase
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         // zero words for everything but a good transform
         if (cmd_ff == mmac_pkg::CMD_TRANSFORM && !bad_ff) begin
            for (int l = 0; l < mmac_pkg::LANES; l++) norm_ff[l] <= res[l];
            status_ff <= (|sat_vec) ? mmac_pkg::STAT_SAT : mmac_pkg::STAT_OK;
         end else begin
            for (int l = 0; l < mmac_pkg::LANES; l++) norm_ff[l] <= '0;
            status_ff <= (cmd_ff == mmac_pkg::CMD_TRANSFORM)
                       ? mmac_pkg::STAT_SPAN : mmac_pkg::STAT_OK;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.norm_x = norm_ff[0];
   assign rsp_chan.norm_y = norm_ff[1];
   assign rsp_chan.norm_z = norm_ff[2];
   assign rsp_chan.status = status_ff;

endmodule
